[src/pngce_pkg.sv]
// ----------------------------------------------------------------------------
// pngce_pkg: shared types and constants of the PNG chunk extractor
// Holds the status and class codes, the signature table, the CRC-32 byte
// update and the result word type.
// ----------------------------------------------------------------------------
`default_nettype none

package pngce_pkg;

  // CRC-32, reflected form
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

  // type field of the end chunk
  localparam logic [31:0] IEND_TYPE = 32'h49454E44;

  // bytes of length, type and CRC around the chunk data
  localparam int unsigned CHUNK_OVERHEAD = 12;

  // final status codes
  typedef enum logic [2:0] {
    ST_FOUND_OK  = 3'd0,
    ST_CRC_BAD   = 3'd1,
    ST_TRUNCATED = 3'd2,
    ST_NOT_PNG   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  // result kinds
  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_t;

  // class of the chunk being walked
  typedef enum logic [1:0] {
    CLS_OTHER  = 2'd0,
    CLS_TARGET = 2'd1,
    CLS_IEND   = 2'd2
  } chunk_class_t;

  // one result word
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload;
    status_t     status;
    logic        is_last;
  } result_t;

  // signature byte at a given position
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0:    v = 8'h89;
      3'd1:    v = 8'h50;
      3'd2:    v = 8'h4E;
      3'd3:    v = 8'h47;
      3'd4:    v = 8'h0D;
      3'd5:    v = 8'h0A;
      3'd6:    v = 8'h1A;
      3'd7:    v = 8'h0A;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // one byte through the CRC-32 register, eight bit steps
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[src/pngce_in_if.sv]
// ----------------------------------------------------------------------------
// pngce_in_if: byte input channel
// One file byte per word, with a flag on the final byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface pngce_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

`default_nettype wire

[src/pngce_out_if.sv]
// ----------------------------------------------------------------------------
// pngce_out_if: result channel
// Payload bytes of the matched chunk and the closing status.
// ----------------------------------------------------------------------------
`default_nettype none

interface pngce_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] payload_byte;
  logic [2:0] status;
  logic       is_last;

  modport source (output valid, output result_kind, output payload_byte,
                  output status, output is_last, input ready);
  modport sink   (input valid, input result_kind, input payload_byte,
                  input status, input is_last, output ready);
endinterface

`default_nettype wire

[src/pngce_cfg_if.sv]
// ----------------------------------------------------------------------------
// pngce_cfg_if: configuration write channel
// Carries the target chunk type register value.
// ----------------------------------------------------------------------------
`default_nettype none

interface pngce_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] target_chunk_type;

  modport source (output valid, output target_chunk_type, input ready);
  modport sink   (input valid, input target_chunk_type, output ready);
endinterface

`default_nettype wire

[src/png_chunk_extract_crc_check.sv]
// ----------------------------------------------------------------------------
// png_chunk_extract_crc_check: PNG chunk extractor with CRC-32 check
// Checks the signature, walks the chunks, streams the data of the first
// chunk of the target type and closes with a status word.
// ----------------------------------------------------------------------------
//
//  channel     dir  words
//  byte_in     in   byte_value, last_byte: one file byte
//  result_out  out  result_kind, payload_byte, status, is_last
//  cfg         in   target_chunk_type, written between files
//
//  One byte is taken per cycle while byte_in is ready; the parse state and CRC
//  update in the cycle of acceptance and its results enter a four-word output queue.
//  A byte gives at most two results; byte_in is ready while two queue slots
//  are free, so a stalled result side holds the input once three words wait.
//  Results are registered in the queue before they appear on result_out.
//  rst is synchronous; cfg is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module png_chunk_extract_crc_check (
  input  wire              clk,
  input  wire              rst,
  pngce_in_if.sink         byte_in,
  pngce_out_if.source      result_out,
  pngce_cfg_if.sink        cfg
);

  typedef enum logic [2:0] {
    PH_SIG   = 3'b001,
    PH_CHUNK = 3'b010,
    PH_DONE  = 3'b100
  } phase_t;

  // parse state
  phase_t                  phase, phase_next;
  logic [2:0]              sig_cnt, sig_cnt_next;
  logic [33:0]             pos, pos_next;
  logic [31:0]             chunk_length, chunk_length_next;
  logic [31:0]             type_shift, type_shift_next;
  logic [31:0]             running_crc, running_crc_next;
  logic [31:0]             received_crc, received_crc_next;
  pngce_pkg::chunk_class_t chunk_class, chunk_class_next;
  logic [31:0]             target_type;

  // result queue
  pngce_pkg::result_t      fifo [4];
  logic [1:0]              head, tail;
  logic [2:0]              count;

  // results of the current byte
  logic                    res_a_v, res_b_v;
  pngce_pkg::result_t      res_a, res_b;

  logic                    in_acc, out_acc;
  logic [7:0]              b;
  logic                    last;
  logic [33:0]             data_end;
  logic [33:0]             crc_end;
  logic [31:0]             type_now;
  logic                    sig_ok;
  logic                    decided;
  logic                    pay_v;
  logic                    st_v;
  pngce_pkg::status_t      st_code;

  assign in_acc  = byte_in.valid && byte_in.ready;
  assign out_acc = result_out.valid && result_out.ready;
  assign b       = byte_in.byte_value;
  assign last    = byte_in.last_byte;

  assign byte_in.ready = (count <= 3'd2);
  assign cfg.ready     = 1'b1;

  // chunk boundaries relative to the chunk start
  assign data_end = {2'b00, chunk_length} + 34'd8;
  assign crc_end  = {2'b00, chunk_length} + 34'd11;
  assign type_now = {type_shift[23:0], b};
  assign sig_ok   = (b == pngce_pkg::sig_byte(sig_cnt));

  // next parse state and results of one byte
  always_comb begin
    phase_next        = phase;
    sig_cnt_next      = sig_cnt;
    pos_next          = pos;
    chunk_length_next = chunk_length;
    type_shift_next   = type_shift;
    running_crc_next  = running_crc;
    received_crc_next = received_crc;
    chunk_class_next  = chunk_class;
    decided           = 1'b0;
    pay_v             = 1'b0;
    st_v              = 1'b0;
    st_code           = pngce_pkg::ST_FOUND_OK;

    case (phase)
      PH_SIG: begin
        if (!sig_ok) begin
          st_v    = 1'b1;
          st_code = pngce_pkg::ST_NOT_PNG;
          decided = 1'b1;
        end else begin
          sig_cnt_next = sig_cnt + 3'd1;
          if (sig_cnt == 3'd7) begin
            phase_next = PH_CHUNK;
            pos_next   = '0;
          end
        end
        if (last && !decided) begin
          st_v    = 1'b1;
          st_code = (sig_ok && sig_cnt == 3'd7) ? pngce_pkg::ST_NOT_FOUND
                                                 : pngce_pkg::ST_NOT_PNG;
          decided = 1'b1;
        end
      end
      PH_CHUNK: begin
        pos_next = pos + 34'd1;
        if (pos < 34'd4) begin
          chunk_length_next = {chunk_length[23:0], b};
        end else if (pos < 34'd8) begin
          type_shift_next  = type_now;
          running_crc_next = pngce_pkg::crc_byte(running_crc, b);
          if (pos == 34'd7) begin
            if (type_now == target_type) begin
              chunk_class_next = pngce_pkg::CLS_TARGET;
            end else if (type_now == pngce_pkg::IEND_TYPE) begin
              chunk_class_next = pngce_pkg::CLS_IEND;
            end else begin
              chunk_class_next = pngce_pkg::CLS_OTHER;
            end
          end
        end else if (pos < data_end) begin
          running_crc_next = pngce_pkg::crc_byte(running_crc, b);
          pay_v            = (chunk_class == pngce_pkg::CLS_TARGET);
        end else begin
          received_crc_next = {received_crc[23:0], b};
          // last CRC byte closes the chunk
          if (pos == crc_end) begin
            if (chunk_class == pngce_pkg::CLS_TARGET) begin
              st_v    = 1'b1;
              st_code = ((running_crc ^ pngce_pkg::CRC_ONES) == received_crc_next)
                        ? pngce_pkg::ST_FOUND_OK : pngce_pkg::ST_CRC_BAD;
              decided = 1'b1;
            end else if (chunk_class == pngce_pkg::CLS_IEND) begin
              st_v    = 1'b1;
              st_code = pngce_pkg::ST_NOT_FOUND;
              decided = 1'b1;
            end else begin
              pos_next          = '0;
              chunk_length_next = '0;
              type_shift_next   = '0;
              received_crc_next = '0;
              running_crc_next  = pngce_pkg::CRC_ONES;
              chunk_class_next  = pngce_pkg::CLS_OTHER;
            end
          end
        end
        if (last && !decided) begin
          st_v    = 1'b1;
          st_code = (pos_next < 34'(pngce_pkg::CHUNK_OVERHEAD))
                    ? pngce_pkg::ST_NOT_FOUND : pngce_pkg::ST_TRUNCATED;
          decided = 1'b1;
        end
      end
      PH_DONE: begin
        decided = 1'b1;
      end
      default: begin
        decided = 1'b1;
      end
    endcase

    if (decided) begin
      phase_next = PH_DONE;
    end

    // end of file rearms for the next one
    if (last) begin
      phase_next        = PH_SIG;
      sig_cnt_next      = '0;
      pos_next          = '0;
      chunk_length_next = '0;
      type_shift_next   = '0;
      running_crc_next  = pngce_pkg::CRC_ONES;
      received_crc_next = '0;
      chunk_class_next  = pngce_pkg::CLS_OTHER;
    end
  end

  // order the results: payload first, status after
  always_comb begin
    pngce_pkg::result_t pay_w, st_w;
    pay_w.kind    = pngce_pkg::KIND_PAYLOAD;
    pay_w.payload = b;
    pay_w.status  = pngce_pkg::ST_FOUND_OK;
    pay_w.is_last = 1'b0;
    st_w.kind     = pngce_pkg::KIND_STATUS;
    st_w.payload  = 8'd0;
    st_w.status   = st_code;
    st_w.is_last  = 1'b1;
    res_a_v = in_acc && (pay_v || st_v);
    res_b_v = in_acc && pay_v && st_v;
    res_a   = pay_v ? pay_w : st_w;
    res_b   = st_w;
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SIG;
      sig_cnt      <= '0;
      pos          <= '0;
      chunk_length <= '0;
      type_shift   <= '0;
      running_crc  <= pngce_pkg::CRC_ONES;
      received_crc <= '0;
      chunk_class  <= pngce_pkg::CLS_OTHER;
    end else if (in_acc) begin
      phase        <= phase_next;
      sig_cnt      <= sig_cnt_next;
      pos          <= pos_next;
      chunk_length <= chunk_length_next;
      type_shift   <= type_shift_next;
      running_crc  <= running_crc_next;
      received_crc <= received_crc_next;
      chunk_class  <= chunk_class_next;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      target_type <= '0;
    end else if (cfg.valid && cfg.ready) begin
      target_type <= cfg.target_chunk_type;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (res_a_v) begin
      fifo[tail] <= res_a;
    end
    if (res_b_v) begin
      fifo[tail + 2'd1] <= res_b;
    end
  end

  // result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (out_acc) begin
        head <= head + 2'd1;
      end
      tail  <= tail + {1'b0, res_a_v} + {1'b0, res_b_v};
      count <= count + {2'b00, res_a_v} + {2'b00, res_b_v} - {2'b00, out_acc};
    end
  end

  assign result_out.valid        = (count != 3'd0);
  assign result_out.result_kind  = fifo[head].kind;
  assign result_out.payload_byte = fifo[head].payload;
  assign result_out.status       = fifo[head].status;
  assign result_out.is_last      = fifo[head].is_last;

endmodule

`default_nettype wire
